/* hw/rtl/tlli_pkg.sv */
// Package for the tilt LED level indicator: widths, register indexes,
// LED patterns and the stage-two sample record. No dependencies.
package tlli_pkg;

  localparam int unsigned AccelW = 16;
  localparam int unsigned MagW   = AccelW + 1;         // |-32768| needs 17 bits
  localparam int unsigned ProdW  = AccelW + MagW;      // slope * |z|
  localparam int unsigned LedW   = 7;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [AccelW-1:0] SlopeReset = 16'd5734; // tan(5 deg) in Q0.16

  typedef enum logic [CfgIdxW-1:0] {
    REG_X_OFFSET    = 2'd0,
    REG_Y_OFFSET    = 2'd1,
    REG_LEVEL_SLOPE = 2'd2
  } reg_idx_e;

  localparam logic [LedW-1:0] LedLevel     = 7'b000_1000;
  localparam logic [LedW-1:0] LedRollPosYl = 7'b010_0101; // LED1,3,6
  localparam logic [LedW-1:0] LedRollNegYl = 7'b101_0010; // LED2,5,7
  localparam logic [LedW-1:0] LedNickPosXl = 7'b000_0011; // LED1,2
  localparam logic [LedW-1:0] LedNickNegXl = 7'b110_0000; // LED6,7
  localparam logic [LedW-1:0] Led1         = 7'b000_0001;
  localparam logic [LedW-1:0] Led2         = 7'b000_0010;
  localparam logic [LedW-1:0] Led6         = 7'b010_0000;
  localparam logic [LedW-1:0] Led7         = 7'b100_0000;

  typedef struct packed {
    logic             x_pos;   // x > 0
    logic             y_pos;   // y > 0
    logic [MagW-1:0]  x_mag;
    logic [MagW-1:0]  y_mag;
    logic [ProdW-1:0] z_thr;   // level_slope * |z|
  } sample_t;

endpackage

/* hw/rtl/tlli_classify.sv */
// Level tests and LED pattern selection for one offset-corrected sample.
// Depends on tlli_pkg.
module tlli_classify (
  input  tlli_pkg::sample_t             smp_i,
  output logic [tlli_pkg::LedW-1:0]     led_mask_o
);
  import tlli_pkg::*;

  logic lvl_x, lvl_y;

  // |a| * 65536 < slope * |z|
  assign lvl_x = {smp_i.x_mag, 16'h0000} < smp_i.z_thr;
  assign lvl_y = {smp_i.y_mag, 16'h0000} < smp_i.z_thr;

  always_comb begin
    priority if (lvl_x && lvl_y) begin
      led_mask_o = LedLevel;
    end else if (smp_i.x_mag > smp_i.y_mag) begin
      // roll dominant
      if (smp_i.x_pos) begin
        if (lvl_y)            led_mask_o = LedRollPosYl;
        else if (smp_i.y_pos) led_mask_o = Led1;
        else                  led_mask_o = Led6;
      end else begin
        if (lvl_y)            led_mask_o = LedRollNegYl;
        else if (smp_i.y_pos) led_mask_o = Led2;
        else                  led_mask_o = Led7;
      end
    end else begin
      // nick dominant, ties land here
      if (smp_i.y_pos) begin
        if (lvl_x)            led_mask_o = LedNickPosXl;
        else if (smp_i.x_pos) led_mask_o = Led1;
        else                  led_mask_o = Led2;
      end else begin
        if (lvl_x)            led_mask_o = LedNickNegXl;
        else if (smp_i.x_pos) led_mask_o = Led6;
        else                  led_mask_o = Led7;
      end
    end
  end

endmodule

/* hw/rtl/tilt_led_level_indicator.sv */
// Tilt LED level indicator top level: config registers and a three-stage pipe.
// Timing: an accepted start is registered into in_vld_q, then smp_vld_q, then
// out_vld_q, which drives valid_o together with the registered LED mask.
// Throughput: one sample per cycle; busy is never raised. Stages are the input
// register, offset/magnitude/threshold multiply, and level compare to LED mask.
// Reset: pipe emptied, offsets to 0, level_slope to 5734.
// Depends on tlli_pkg and tlli_classify.
module tilt_led_level_indicator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [tlli_pkg::AccelW-1:0] accel_x_i,
  input  logic signed [tlli_pkg::AccelW-1:0] accel_y_i,
  input  logic signed [tlli_pkg::AccelW-1:0] accel_z_i,
  input  logic                              cfg_we_i,
  input  logic [tlli_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [tlli_pkg::AccelW-1:0]       cfg_data_i,
  output logic                              valid_o,
  output logic [tlli_pkg::LedW-1:0]         led_mask_o
);
  import tlli_pkg::*;

  logic [AccelW-1:0] x_offset_q, y_offset_q, slope_q;

  logic              in_vld_q;
  logic [AccelW-1:0] ax_q, ay_q, az_q;

  logic              smp_vld_q;
  sample_t           smp_d, smp_q;

  logic              out_vld_q;
  logic [LedW-1:0]   led_d, led_q;

  logic [AccelW-1:0] x_d, y_d, z_nz;
  logic [MagW-1:0]   x_ext, y_ext, z_ext, z_mag;

  assign busy = 1'b0;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_offset_q <= '0;
      y_offset_q <= '0;
      slope_q    <= SlopeReset;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_X_OFFSET:    x_offset_q <= cfg_data_i;
        REG_Y_OFFSET:    y_offset_q <= cfg_data_i;
        REG_LEVEL_SLOPE: slope_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage 1: input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) in_vld_q <= 1'b0;
    else         in_vld_q <= start && !busy;
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      ax_q <= accel_x_i;
      ay_q <= accel_y_i;
      az_q <= accel_z_i;
    end
  end

  // stage 2: offsets (16-bit wrap), magnitudes, z threshold product
  always_comb begin
    x_d   = ax_q - x_offset_q;
    y_d   = ay_q - y_offset_q;
    z_nz  = (az_q == '0) ? AccelW'(1) : az_q;
    x_ext = {x_d[AccelW-1], x_d};
    y_ext = {y_d[AccelW-1], y_d};
    z_ext = {z_nz[AccelW-1], z_nz};
    z_mag = z_nz[AccelW-1] ? (~z_ext + MagW'(1)) : z_ext;

    smp_d.x_pos = !x_d[AccelW-1] && (x_d != '0);
    smp_d.y_pos = !y_d[AccelW-1] && (y_d != '0);
    smp_d.x_mag = x_d[AccelW-1] ? (~x_ext + MagW'(1)) : x_ext;
    smp_d.y_mag = y_d[AccelW-1] ? (~y_ext + MagW'(1)) : y_ext;
    smp_d.z_thr = ProdW'(slope_q) * ProdW'(z_mag);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) smp_vld_q <= 1'b0;
    else         smp_vld_q <= in_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) smp_q <= smp_d;
  end

  // stage 3: compare and LED pattern
  tlli_classify u_classify (
    .smp_i      (smp_q),
    .led_mask_o (led_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else         out_vld_q <= smp_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (smp_vld_q) led_q <= led_d;
  end

  assign valid_o    = out_vld_q;
  assign led_mask_o = led_q;

endmodule

/* hw/rtl/tlli_checker.sv */
// Port-level checks for the tilt LED level indicator, bound to the top level.
// Depends on tlli_pkg.
module tlli_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic                          valid_o,
  input logic [tlli_pkg::LedW-1:0]     led_mask_o
);
  import tlli_pkg::*;

  // every accepted transaction yields its result on valid_o
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##3 valid_o)
    else $error("result missing after accepted transaction");

  // no result without an earlier accepted transaction
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start && !busy, 3))
    else $error("result without a transaction");

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy)
    else $error("busy raised");

  // only the defined LED patterns can appear
  a_mask_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (led_mask_o == LedLevel || led_mask_o == LedRollPosYl ||
                 led_mask_o == LedRollNegYl || led_mask_o == LedNickPosXl ||
                 led_mask_o == LedNickNegXl || led_mask_o == Led1 ||
                 led_mask_o == Led2 || led_mask_o == Led6 || led_mask_o == Led7))
    else $error("illegal LED pattern");

endmodule

bind tilt_led_level_indicator tlli_checker u_tlli_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .valid_o    (valid_o),
  .led_mask_o (led_mask_o)
);
